FILE: src/upfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upfd_pkg
// Shared constants and types for the upgrade frame deframer.
// ----------------------------------------------------------------------------
package upfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned IDX_W    = 17;
    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'hAA;
    localparam logic [BYTE_W-1:0] CMD_ACK_CODE = 8'h02;

    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 16'd285;

    localparam logic [IDX_W-1:0]  IDX_LEN_HI  = 17'd1;
    localparam logic [IDX_W-1:0]  IDX_LEN_LO  = 17'd2;
    localparam logic [IDX_W-1:0]  IDX_COMMAND = 17'd4;
    localparam logic [IDX_W-1:0]  IDX_PAGE_HI = 17'd5;
    localparam logic [IDX_W-1:0]  IDX_PAGE_LO = 17'd6;
    localparam logic [IDX_W-1:0]  FRAME_OVERHEAD = 17'd2;

    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_BAD      = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_frame_status;

endpackage

FILE: src/upgrade_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upgrade_frame_deframer
// Deframes length-prefixed upgrade frames with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Each item is one received byte and yields exactly one result item. The
// block takes one item per clock cycle and registers its result for the next
// cycle; the frame state and the result register are updated in the same
// single registered stage, so throughput is limited only by output stalls.
// While hunting, bytes other than 0xAA are echoed as discarded. A frame
// carries a big-endian length in bytes 1 and 2 and ends with a checksum
// byte; the last result of a frame reports status, page number, flash
// address, sector-erase need and the reply checksum. A length above
// max_length (register 0, reset 285) aborts the frame with a too-long status.
// ----------------------------------------------------------------------------
module upgrade_frame_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [upfd_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [upfd_pkg::BYTE_W-1:0]         o_data_byte,
    output logic                                o_in_frame,
    output logic [upfd_pkg::IDX_W-1:0]          o_byte_index,
    output logic [upfd_pkg::BYTE_W-1:0]         o_reply_byte,
    output logic                                o_frame_end,
    output logic [1:0]                          o_frame_status,
    output logic [upfd_pkg::LEN_W-1:0]          o_page_number,
    output logic [upfd_pkg::ADDR_W-1:0]         o_flash_address,
    output logic                                o_erase_sector,
    output logic [upfd_pkg::BYTE_W-1:0]         o_reply_checksum,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [upfd_pkg::PADDR_W-1:0]        paddr,
    input  logic [upfd_pkg::PDATA_W-1:0]        pwdata,
    output logic [upfd_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import upfd_pkg::*;

    logic [LEN_W-1:0]  r_max_length;
    logic              r_active;
    logic [IDX_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_len_hi;
    logic [LEN_W-1:0]  r_flen;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_cmd;
    logic [LEN_W-1:0]  r_page;

    logic              n_active;
    logic [IDX_W-1:0]  n_count;
    logic [BYTE_W-1:0] n_len_hi;
    logic [LEN_W-1:0]  n_flen;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] n_cmd;
    logic [LEN_W-1:0]  n_page;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data_byte;
    logic              r_in_frame;
    logic [IDX_W-1:0]  r_byte_index;
    logic [BYTE_W-1:0] r_reply_byte;
    logic              r_frame_end;
    t_frame_status     r_frame_status;
    logic [LEN_W-1:0]  r_page_number;
    logic              r_erase_sector;
    logic [BYTE_W-1:0] r_reply_checksum;

    logic              n_in_frame;
    logic [IDX_W-1:0]  n_byte_index;
    logic [BYTE_W-1:0] n_reply_byte;
    logic              n_frame_end;
    t_frame_status     n_frame_status;
    logic [LEN_W-1:0]  n_page_number;
    logic              n_erase_sector;
    logic [BYTE_W-1:0] n_reply_checksum;

    logic              w_in_acc;
    logic              w_cfg_wr;
    logic [IDX_W-1:0]  w_idx;
    logic [LEN_W-1:0]  w_flen;
    logic [IDX_W-1:0]  w_last;
    logic              w_too_long;
    logic              w_is_last;
    logic [LEN_W-1:0]  w_page_upd;
    logic [BYTE_W-1:0] w_rsum;

    assign o_stall  = r_valid & i_stall;
    assign w_in_acc = i_valid & ~o_stall;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_LENGTH) ?
                      {{(PDATA_W-LEN_W){1'b0}}, r_max_length} : '0;

    always_comb begin
        w_idx      = r_active ? r_count : '0;
        w_flen     = (w_idx == IDX_LEN_LO) ? {r_len_hi, i_rx_byte} : r_flen;
        w_last     = {1'b0, w_flen} + FRAME_OVERHEAD;
        w_too_long = r_active && (w_idx == IDX_LEN_LO) && (w_flen > r_max_length);
        w_is_last  = r_active && !w_too_long && (w_idx >= IDX_LEN_LO) &&
                     (w_idx == w_last);
        if (w_idx == IDX_PAGE_HI) begin
            w_page_upd = {i_rx_byte, {BYTE_W{1'b0}}};
        end else if (w_idx == IDX_PAGE_LO) begin
            w_page_upd = {r_page[LEN_W-1:BYTE_W], i_rx_byte};
        end else begin
            w_page_upd = r_page;
        end
        w_rsum = (w_last >= IDX_PAGE_HI) ? (r_sum - r_cmd + CMD_ACK_CODE) : r_sum;
    end

    always_comb begin
        n_active         = r_active;
        n_count          = r_count;
        n_len_hi         = r_len_hi;
        n_flen           = r_flen;
        n_sum            = r_sum;
        n_cmd            = r_cmd;
        n_page           = r_page;
        n_in_frame       = 1'b0;
        n_byte_index     = '0;
        n_reply_byte     = '0;
        n_frame_end      = 1'b0;
        n_frame_status   = ST_NONE;
        n_page_number    = '0;
        n_erase_sector   = 1'b0;
        n_reply_checksum = '0;
        if (!r_active) begin
            if (i_rx_byte == START_BYTE) begin
                n_active     = 1'b1;
                n_count      = IDX_LEN_HI;
                n_sum        = '0;
                n_cmd        = '0;
                n_page       = '0;
                n_len_hi     = '0;
                n_in_frame   = 1'b1;
                n_reply_byte = i_rx_byte;
            end
        end else begin
            n_in_frame   = 1'b1;
            n_byte_index = w_idx;
            n_reply_byte = i_rx_byte;
            if (w_idx == IDX_LEN_HI) begin
                n_len_hi = i_rx_byte;
            end
            n_flen = w_flen;
            if (w_too_long) begin
                n_frame_end    = 1'b1;
                n_frame_status = ST_TOO_LONG;
                n_active       = 1'b0;
                n_count        = '0;
            end else begin
                n_page = w_page_upd;
                if (w_is_last) begin
                    n_frame_end      = 1'b1;
                    n_frame_status   = (i_rx_byte == r_sum) ? ST_GOOD : ST_BAD;
                    n_reply_checksum = w_rsum;
                    n_reply_byte     = w_rsum;
                    n_page_number    = (w_last >= IDX_PAGE_LO) ? w_page_upd : '0;
                    n_erase_sector   = (n_page_number[3:0] == 4'd0);
                    n_active         = 1'b0;
                    n_count          = '0;
                end else begin
                    if (w_idx == IDX_COMMAND) begin
                        n_cmd        = i_rx_byte;
                        n_reply_byte = CMD_ACK_CODE;
                    end
                    n_sum   = r_sum + i_rx_byte;
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
            r_active     <= 1'b0;
            r_count      <= '0;
            r_len_hi     <= '0;
            r_flen       <= '0;
            r_sum        <= '0;
            r_cmd        <= '0;
            r_page       <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_MAX_LENGTH)) begin
                r_max_length <= pwdata[LEN_W-1:0];
            end
            if (w_in_acc) begin
                r_active <= n_active;
                r_count  <= n_count;
                r_len_hi <= n_len_hi;
                r_flen   <= n_flen;
                r_sum    <= n_sum;
                r_cmd    <= n_cmd;
                r_page   <= n_page;
                r_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data_byte      <= i_rx_byte;
            r_in_frame       <= n_in_frame;
            r_byte_index     <= n_byte_index;
            r_reply_byte     <= n_reply_byte;
            r_frame_end      <= n_frame_end;
            r_frame_status   <= n_frame_status;
            r_page_number    <= n_page_number;
            r_erase_sector   <= n_erase_sector;
            r_reply_checksum <= n_reply_checksum;
        end
    end

    assign o_valid          = r_valid;
    assign o_data_byte      = r_data_byte;
    assign o_in_frame       = r_in_frame;
    assign o_byte_index     = r_byte_index;
    assign o_reply_byte     = r_reply_byte;
    assign o_frame_end      = r_frame_end;
    assign o_frame_status   = r_frame_status;
    assign o_page_number    = r_page_number;
    assign o_flash_address  = {r_page_number, {BYTE_W{1'b0}}};
    assign o_erase_sector   = r_erase_sector;
    assign o_reply_checksum = r_reply_checksum;

    a_end_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_in_frame)
        else $error("frame end reported on a discarded item");

    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_frame_status != ST_NONE) == o_frame_end))
        else $error("frame status and frame end disagree");

    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_frame_end) |=> !r_active)
        else $error("deframer did not return to hunting after frame end");

    a_hunt_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_frame) |-> (o_byte_index == '0 && o_reply_byte == '0))
        else $error("discarded item carries frame fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_count != '0))
        else $error("active frame with zero byte count");

endmodule
